/* sv/mrma_pkg.sv */
// types and constants shared by the modbus region map access block
`timescale 1ns / 1ps
`default_nettype none

package mrma_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_REGS   = 4;
    localparam int REG_CFG_W  = 45;

    // element arithmetic: 17-bit relative index plus 10-bit store word offset
    localparam int REL_W  = 17;
    localparam int WOFF_W = 10;
    localparam int ACC_W  = 18;

    typedef enum logic [1:0] {
        SPACE_COILS    = 2'd0,
        SPACE_DISCRETE = 2'd1,
        SPACE_HOLDING  = 2'd2,
        SPACE_INPUT    = 2'd3
    } t_space;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    // region register layout, msb first
    typedef struct packed {
        logic [WOFF_W-1:0] woff;
        logic [15:0]       size;
        logic [15:0]       base;
        t_space            space;
        logic              valid;
    } t_region;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_MOD,
        ST_ACCESS,
        ST_RDWAIT
    } t_state;

endpackage

`default_nettype wire

/* sv/mrma_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mrma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/modbus_region_map_access.sv */
// modbus region map access: region lookup, store address reduction and word store access
// sequence: region scan, address calc, MOD_STEPS reduction steps and store access,
//   plus a read wait for reads and bit writes; MOD_STEPS = 2 (quotient, then subtract)
// an element outside its transfer or with no matching region reports after the scan alone
// throughput: one element at a time; busy stays high until the result beat is issued,
//   covering the one-region-per-cycle scan and the reciprocal-multiply address reduction
// synchronous active-low reset clears the sequencer, result strobe and region registers;
// the word store has no reset, the receiver cannot stall the result beat
`timescale 1ns / 1ps
`default_nettype none

module modbus_region_map_access
    import mrma_pkg::*;
#(
    parameter int REGIONS     = 4,
    parameter int STORE_WORDS = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_cmd,
    input  wire logic [1:0]            i_space,
    input  wire logic [15:0]           i_start_addr,
    input  wire logic [15:0]           i_count,
    input  wire logic [15:0]           i_elem_index,
    input  wire logic [15:0]           i_write_value,
    input  wire logic                  i_swap_bytes,
    // result beat
    output logic                       o_valid,
    output logic                       o_ok,
    output logic [15:0]                o_read_value,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    // only the first four regions have registers
    localparam int REG_N     = (REGIONS < CFG_REGS) ? REGIONS : CFG_REGS;
    localparam int REG_W     = (REG_N > 1) ? $clog2(REG_N) : 1;
    localparam int ADDR_W    = $clog2(STORE_WORDS);
    // address reduction: quotient by reciprocal multiply, then one subtract
    localparam int MOD_STEPS = 2;
    localparam int STEP_W    = 1;
    // reciprocal exact for every sum below 2**ACC_W
    localparam int RCP_SHIFT = ACC_W + $clog2(STORE_WORDS);
    localparam int RCP_W     = ACC_W + 1;
    localparam int PROD_W    = ACC_W + RCP_W;
    localparam longint unsigned RCP =
        ((64'd1 << RCP_SHIFT) + 64'(STORE_WORDS) - 64'd1) / 64'(STORE_WORDS);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    t_region          r_region [REG_N];
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < REG_N; r++) begin
                r_region[r] <= '0;
            end
        end else begin
            for (int r = 0; r < REG_N; r++) begin
                if (cfg_wr && cfg_idx == 2'(r)) begin
                    r_region[r] <= t_region'(pwdata[REG_CFG_W-1:0]);
                end
            end
        end
    end

    // readback, unimplemented registers read as zero
    always_comb begin
        prdata = '0;
        for (int r = 0; r < REG_N; r++) begin
            if (cfg_idx == 2'(r)) begin
                prdata = CFG_DATA_W'(r_region[r]);
            end
        end
    end

    // ---------------------------------------------------------------
    // latched command
    // ---------------------------------------------------------------
    t_state           r_state, n_state;
    t_cmd             r_cmd;
    t_space           r_space;
    logic [15:0]      r_start, r_count, r_elem, r_wval;
    logic             r_swap;
    logic             accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_space <= t_space'(i_space);
            r_start <= i_start_addr;
            r_count <= i_count;
            r_elem  <= i_elem_index;
            r_wval  <= i_write_value;
            r_swap  <= i_swap_bytes;
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    logic [REG_W-1:0]  r_idx, n_idx;
    logic [15:0]       r_base, n_base;
    logic [WOFF_W-1:0] r_woff, n_woff;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]  r_quo, n_quo;
    logic [3:0]        r_bitpos, n_bitpos;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              r_ok, n_ok;
    logic [15:0]       r_rval, n_rval;

    // shared compare unit inputs
    t_region           sel_region;
    logic              elem_out;
    logic              scan_hit;
    logic              scan_last;
    logic              bit_space;
    logic [REL_W-1:0]  rel;
    logic [PROD_W-1:0] quo_prod;
    logic [ACC_W-1:0]  quo_mul;

    // store port
    logic              ram_en, ram_we;
    logic [15:0]       ram_wdata, ram_rdata;

    always_comb begin
        sel_region = '0;
        for (int r = 0; r < REG_N; r++) begin
            if (r_idx == REG_W'(r)) begin
                sel_region = r_region[r];
            end
        end
    end

    assign elem_out  = (r_elem >= r_count);
    // region covers start .. start + count - 1, sums at 17 bits so nothing wraps
    assign scan_hit  = sel_region.valid && (sel_region.space == r_space)
                       && (sel_region.base <= r_start)
                       && (({1'b0, sel_region.base} + {1'b0, sel_region.size})
                           >= ({1'b0, r_start} + {1'b0, r_count}));
    assign scan_last = (r_idx == REG_W'(REG_N - 1));
    assign bit_space = (r_space == SPACE_COILS) || (r_space == SPACE_DISCRETE);
    assign rel       = {1'b0, r_start - r_base} + {1'b0, r_elem};
    assign quo_prod  = PROD_W'(r_acc) * PROD_W'(RCP);
    assign quo_mul   = r_quo * ACC_W'(STORE_WORDS);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (elem_out) begin
                    n_state = ST_IDLE;
                end else if (scan_hit) begin
                    n_state = ST_CALC;
                end else if (scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CALC: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                if (r_step == '0) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (r_cmd == CMD_WRITE && !bit_space) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RDWAIT;
                end
            end
            ST_RDWAIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb begin
        n_idx       = r_idx;
        n_base      = r_base;
        n_woff      = r_woff;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_bitpos    = r_bitpos;
        n_step      = r_step;
        n_out_valid = 1'b0;
        n_ok        = r_ok;
        n_rval      = r_rval;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = r_wval;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
            end
            ST_SCAN: begin
                if (elem_out || (!scan_hit && scan_last)) begin
                    // failed beat
                    n_out_valid = 1'b1;
                    n_ok        = 1'b0;
                    n_rval      = '0;
                end else if (scan_hit) begin
                    n_base = sel_region.base;
                    n_woff = sel_region.woff;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_CALC: begin
                // bit spaces pack sixteen elements per word
                n_acc    = ACC_W'(r_woff) + (bit_space ? ACC_W'(rel >> 4) : ACC_W'(rel));
                n_bitpos = rel[3:0];
                n_step   = STEP_W'(MOD_STEPS - 1);
            end
            ST_MOD: begin
                if (r_step != '0) begin
                    // quotient of the sum by the store depth
                    n_quo  = ACC_W'(quo_prod >> RCP_SHIFT);
                    n_step = r_step - 1'b1;
                end else begin
                    // remainder is the store word address
                    n_acc = r_acc - quo_mul;
                end
            end
            ST_ACCESS: begin
                ram_en = 1'b1;
                ram_we = (r_cmd == CMD_WRITE) && !bit_space;
                ram_wdata = r_swap ? {r_wval[7:0], r_wval[15:8]} : r_wval;
                if (ram_we) begin
                    n_out_valid = 1'b1;
                    n_ok        = 1'b1;
                    n_rval      = '0;
                end
            end
            ST_RDWAIT: begin
                n_out_valid = 1'b1;
                n_ok        = 1'b1;
                if (r_cmd == CMD_WRITE) begin
                    // modify one bit of the word just read
                    ram_en               = 1'b1;
                    ram_we               = 1'b1;
                    ram_wdata            = ram_rdata;
                    ram_wdata[r_bitpos]  = r_wval[0];
                    n_rval               = '0;
                end else if (bit_space) begin
                    n_rval = {15'd0, ram_rdata[r_bitpos]};
                end else begin
                    n_rval = ram_rdata;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_woff   <= n_woff;
        r_acc    <= n_acc;
        r_quo    <= n_quo;
        r_bitpos <= n_bitpos;
        r_ok     <= n_ok;
        r_rval   <= n_rval;
    end

    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_read_value = r_rval;

    // ---------------------------------------------------------------
    // word store
    // ---------------------------------------------------------------
    mrma_ram #(
        .WIDTH (16),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (r_acc[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

`ifndef ASSERT_OFF
    // a result beat always coincides with the sequencer back in idle
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // a failed element never carries data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_read_value == 16'd0))
        else $error("failed beat with nonzero data");

    // the reduction leaves the store address in range
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS) |-> (r_acc < ACC_W'(STORE_WORDS)))
        else $error("store address not reduced");

    // an accepted command always leaves the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command accepted without going busy");

    // store writes only from the access or read-modify-write steps
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_ACCESS) || (r_state == ST_RDWAIT)))
        else $error("store write outside access steps");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for the modbus region map access block
`timescale 1ns / 1ps

module tb_top;
    import mrma_pkg::*;

    localparam int REGIONS     = 4;
    localparam int STORE_WORDS = 1024;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat in either direction
    localparam int SETTLE      = 32;     // above the worst start-to-result latency
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 25;

    // one transfer element as driven on the command channel
    typedef struct {
        t_cmd        cmd;
        t_space      space;
        logic [15:0] start_addr;
        logic [15:0] count;
        logic [15:0] elem_index;
        logic [15:0] write_value;
        logic        swap_bytes;
    } t_element;

    // one result beat
    typedef struct {
        logic        ok;
        logic [15:0] value;
    } t_beat;

    // region lookup and word store mirror, plus the queue of beats still to come
    class map_access_tracker;
        t_region     regions[REGIONS];
        logic [15:0] words[STORE_WORDS];
        t_beat       expected_beats[$];
        int          errors;

        function new();
            foreach (regions[i]) regions[i] = '0;
            errors = 0;
        endfunction

        function void set_region(int idx, logic [63:0] data);
            regions[idx] = t_region'(data[REG_CFG_W-1:0]);
        endfunction

        // work out the beat that an accepted element must produce
        function void note_element(t_element e);
            t_beat       b;
            t_region     c;
            t_region     sel;
            bit          hit;
            logic [16:0] rel;
            logic [9:0]  addr;
            logic [15:0] w;
            b.ok    = 1'b0;
            b.value = '0;
            hit     = 1'b0;
            sel     = '0;
            // element inside its transfer, else a plain miss
            if (e.elem_index < e.count) begin
                // first valid region of the same space that covers the whole transfer
                for (int i = 0; i < REGIONS; i++) begin
                    c = regions[i];
                    if (!hit && c.valid && c.space == e.space && c.base <= e.start_addr &&
                        ({1'b0, c.base} + {1'b0, c.size}) >=
                        ({1'b0, e.start_addr} + {1'b0, e.count})) begin
                        hit = 1'b1;
                        sel = c;
                    end
                end
            end
            if (hit) begin
                rel  = {1'b0, e.start_addr} - {1'b0, sel.base} + {1'b0, e.elem_index};
                b.ok = 1'b1;
                if (e.space == SPACE_COILS || e.space == SPACE_DISCRETE) begin
                    // sixteen bits per word, lsb first, store address wraps
                    addr = sel.woff + rel[13:4];
                    w    = words[addr];
                    if (e.cmd == CMD_WRITE) begin
                        w[rel[3:0]] = e.write_value[0];
                        words[addr] = w;
                    end else begin
                        b.value = {15'b0, w[rel[3:0]]};
                    end
                end else begin
                    addr = sel.woff + rel[9:0];
                    if (e.cmd == CMD_WRITE) begin
                        words[addr] = e.swap_bytes ?
                            {e.write_value[7:0], e.write_value[15:8]} : e.write_value;
                    end else begin
                        b.value = words[addr];
                    end
                end
            end
            expected_beats.push_back(b);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // compare one result beat against the oldest expectation
        task check_beat(logic ok, logic [15:0] value);
            t_beat want;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending ok=%b value=%h",
                    ok, value));
            end else begin
                want = expected_beats.pop_front();
                if (ok !== want.ok)
                    report_mismatch($sformatf("ok %b, want %b", ok, want.ok));
                if (value !== want.value)
                    report_mismatch($sformatf("read_value %h, want %h", value, want.value));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cmd;
    logic [1:0]            i_space;
    logic [15:0]           i_start_addr;
    logic [15:0]           i_count;
    logic [15:0]           i_elem_index;
    logic [15:0]           i_write_value;
    logic                  i_swap_bytes;
    logic                  o_valid;
    logic                  o_ok;
    logic [15:0]           o_read_value;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    map_access_tracker sb = new();
    int                stall_cycles = 0;

    modbus_region_map_access #(
        .REGIONS     (REGIONS),
        .STORE_WORDS (STORE_WORDS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_space       (i_space),
        .i_start_addr  (i_start_addr),
        .i_count       (i_count),
        .i_elem_index  (i_elem_index),
        .i_write_value (i_write_value),
        .i_swap_bytes  (i_swap_bytes),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_read_value  (o_read_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result beats are sampled at the edge that ends their cycle
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_beat(o_ok, o_read_value);
    end

    // watchdog: any beat, command or result, restarts the count
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic logic [63:0] region_word(bit valid, t_space sp, int base, int size,
                                                int woff);
        t_region g;
        g.valid = valid;
        g.space = sp;
        g.base  = 16'(base);
        g.size  = 16'(size);
        g.woff  = 10'(woff);
        return 64'(g);
    endfunction

    // random region, bits above the register width left random as well
    function automatic logic [63:0] random_region();
        logic [63:0] d;
        logic [63:0] r;
        int          size;
        case ($urandom_range(9))
            0:       size = 0;
            1:       size = 16'hFFFF;
            2, 3, 4, 5: size = $urandom_range(64, 1);
            default: size = $urandom_range(65535, 1);
        endcase
        d = {$urandom, $urandom};
        r = region_word($urandom_range(9) != 0, t_space'($urandom_range(3)),
            $urandom_range(1) ? $urandom_range(255) : $urandom_range(65535), size,
            $urandom_range(1023));
        d[REG_CFG_W-1:0] = r[REG_CFG_W-1:0];
        return d;
    endfunction

    function automatic t_element mk_element(t_cmd cmd, t_space sp, int st, int cnt, int k,
                                            int wv, bit swap);
        t_element e;
        e.cmd         = cmd;
        e.space       = sp;
        e.start_addr  = 16'(st);
        e.count       = 16'(cnt);
        e.elem_index  = 16'(k);
        e.write_value = 16'(wv);
        e.swap_bytes  = swap;
        return e;
    endfunction

    // mostly transfers that fit a configured region, the rest noise
    function automatic t_element random_element();
        t_element e;
        t_region  g;
        int       b;
        int       s;
        int       cnt;
        int       hi;
        e.cmd         = t_cmd'($urandom_range(1));
        e.write_value = 16'($urandom_range(65535));
        e.swap_bytes  = 1'($urandom_range(1));
        g = sb.regions[$urandom_range(REGIONS - 1)];
        b = g.base;
        s = g.size;
        if ($urandom_range(4) != 0 && s != 0) begin
            cnt = ($urandom_range(9) < 7) ? $urandom_range((s < 16) ? s : 16, 1)
                                          : $urandom_range(s, 1);
            hi = b + s - cnt;
            if (hi > 65535)
                hi = 65535;
            e.space      = g.space;
            e.start_addr = 16'($urandom_range(hi, b));
            e.count      = 16'(cnt);
            e.elem_index = 16'($urandom_range(cnt - 1));
            // now and then one past the last element
            if ($urandom_range(9) == 0 && cnt <= 65534)
                e.elem_index = 16'(cnt);
        end else begin
            e.space      = t_space'($urandom_range(3));
            e.start_addr = 16'($urandom_range(65535));
            e.count      = 16'($urandom_range(65535, 1));
            e.elem_index = 16'($urandom_range(65534));
        end
        return e;
    endfunction

    // register write: setup cycle, then access cycle held until pready
    task apb_write(int idx, logic [63:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 8);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_region(idx, data);
    endtask

    // one command beat; start stays high on return so back-to-back beats need no gap
    task send_element(t_element e, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= e.cmd;
        i_space       <= e.space;
        i_start_addr  <= e.start_addr;
        i_count       <= e.count;
        i_elem_index  <= e.elem_index;
        i_write_value <= e.write_value;
        i_swap_bytes  <= e.swap_bytes;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_element(e);
    endtask

    // let every pending beat arrive, then give the block time to go idle
    task drain();
        start <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] d;
        int          off;
        int          idle;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cmd         <= 1'b0;
        i_space       <= '0;
        i_start_addr  <= '0;
        i_count       <= '0;
        i_elem_index  <= '0;
        i_write_value <= '0;
        i_swap_bytes  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all regions invalid after reset, so every element misses
        send_element(mk_element(CMD_READ, SPACE_COILS, 0, 1, 0, 0, 0), 0);
        send_element(mk_element(CMD_WRITE, SPACE_HOLDING, 16'hFFFF, 16'hFFFF, 16'hFFFE,
            16'hFFFF, 1), 0);
        // element index equal to the count
        send_element(mk_element(CMD_READ, SPACE_INPUT, 0, 1, 1, 0, 0), 0);
        drain();

        // preload: one holding region over the whole store, every word written once
        apb_write(0, region_word(1, SPACE_HOLDING, 0, STORE_WORDS, 0));
        for (int n = 0; n < STORE_WORDS; n++)
            send_element(mk_element(CMD_WRITE, SPACE_HOLDING, 0, STORE_WORDS, n,
                $urandom_range(65535), 1'($urandom_range(1))), 35);
        drain();

        // directed map: coils near the store end, wide holding ranges, an invalid region
        apb_write(0, region_word(1, SPACE_COILS, 16'h0010, 16'h0040, 10'h3FF));
        apb_write(1, region_word(1, SPACE_HOLDING, 0, 16'hFFFF, 10'h155));
        apb_write(2, region_word(1, SPACE_HOLDING, 16'hFFFF, 16'hFFFF, 10'h3FF));
        apb_write(3, region_word(0, SPACE_INPUT, 0, 16'hFFFF, 10'h200));
        // bit write uses bit zero only and ignores swap; store word wraps
        send_element(mk_element(CMD_WRITE, SPACE_COILS, 16'h10, 16'h40, 16'h3F, 16'hFFFE, 1), 0);
        send_element(mk_element(CMD_READ, SPACE_COILS, 16'h10, 16'h40, 16'h3F, 0, 0), 0);
        send_element(mk_element(CMD_WRITE, SPACE_COILS, 16'h10, 16'h40, 16'h3F, 16'h0001, 0), 0);
        send_element(mk_element(CMD_READ, SPACE_COILS, 16'h10, 16'h40, 16'h3F, 0, 0), 0);
        // one past the region end, one below its base, exactly its last element
        send_element(mk_element(CMD_READ, SPACE_COILS, 16'h10, 16'h41, 0, 0, 0), 0);
        send_element(mk_element(CMD_READ, SPACE_COILS, 16'h0F, 1, 0, 0, 0), 0);
        send_element(mk_element(CMD_READ, SPACE_COILS, 16'h4F, 1, 0, 0, 0), 0);
        // top address, sums past 16 bits, byte swap
        send_element(mk_element(CMD_WRITE, SPACE_HOLDING, 16'hFFFF, 1, 0, 16'h12AB, 1), 0);
        send_element(mk_element(CMD_READ, SPACE_HOLDING, 16'hFFFF, 1, 0, 0, 0), 0);
        send_element(mk_element(CMD_WRITE, SPACE_HOLDING, 0, 16'hFFFF, 16'hFFFE, 16'hA55A, 0), 0);
        send_element(mk_element(CMD_READ, SPACE_HOLDING, 0, 16'hFFFF, 16'hFFFE, 0, 0), 0);
        send_element(mk_element(CMD_WRITE, SPACE_HOLDING, 16'hFFFF, 16'hFFFF, 16'hFFFE,
            16'h00FF, 1), 0);
        send_element(mk_element(CMD_READ, SPACE_HOLDING, 16'hFFFF, 16'hFFFF, 16'hFFFE, 0, 0), 0);
        // invalid region skipped, space mismatch, element equal to count
        send_element(mk_element(CMD_READ, SPACE_INPUT, 0, 1, 0, 0, 0), 0);
        send_element(mk_element(CMD_READ, SPACE_DISCRETE, 16'h10, 1, 0, 0, 0), 0);
        send_element(mk_element(CMD_WRITE, SPACE_HOLDING, 0, 5, 5, 16'h5A5A, 0), 0);
        send_element(mk_element(CMD_READ, SPACE_HOLDING, 0, 5, 4, 0, 0), 0);
        send_element(mk_element(CMD_READ, SPACE_HOLDING, 0, 16'hFFFF, 0, 0, 0), 0);
        drain();

        // random phases, a fresh map for each, sender idling most in the middle phases and never in the last two
        for (int p = 0; p < PHASES; p++) begin
            off  = $urandom_range(3);
            idle = (p < 2) ? 35 : (p < 4) ? 68 : 0;
            for (int r = 0; r < REGIONS; r++) begin
                d = random_region();
                // one valid region per space
                if (p == 0) begin
                    d[2:1] = 2'((r + off) % 4);
                    d[0]   = 1'b1;
                end
                // register extremes
                if (p == 2 && r == 0)
                    d = '1;
                if (p == 2 && r == 1)
                    d = '0;
                apb_write(r, d);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_element(random_element(), idle);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
